[rtl/eowq_pkg.sv]
`timescale 1ns / 1ps

package eowq_pkg;

    localparam int ID_W      = 4;
    localparam int WAITERS   = 1 << ID_W;
    localparam int SLOT_W    = ID_W;
    localparam int CNT_W     = $clog2(WAITERS + 1);
    localparam int TICK_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 1;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WAIT  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_GRANTED   = 2'd0,
        STATUS_TIMED_OUT = 2'd1,
        STATUS_QUEUED    = 2'd2,
        STATUS_REJECTED  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MANUAL_RESET   = 1'd0,
        CFG_START_SIGNALED = 1'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET_ALL,
        ST_TICK,
        ST_FLUSH
    } state_t;

    // Update of the waiter slot table: insert at the tail or remove one slot.
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [SLOT_W-1:0] slot;
        logic              no_expiry;
    } slot_op_t;

endpackage

[rtl/eowq_ram.sv]
`timescale 1ns / 1ps

module eowq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/eowq_slots.sv]
`timescale 1ns / 1ps

module eowq_slots
    import eowq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  slot_op_t           op,
    input  logic [SLOT_W-1:0]  lookup_rank,
    output logic [SLOT_W-1:0]  lookup_slot,
    output logic               lookup_hit,
    output logic [WAITERS-1:0] in_use,
    output logic [WAITERS-1:0] forever_mask,
    output logic [CNT_W-1:0]   count
);

    logic [WAITERS-1:0] in_use_reg;
    logic [WAITERS-1:0] in_use_next;
    logic [WAITERS-1:0] forever_reg;
    logic [WAITERS-1:0] forever_next;
    logic [SLOT_W-1:0]  rank_reg  [WAITERS];
    logic [SLOT_W-1:0]  rank_next [WAITERS];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [SLOT_W-1:0]  rem_rank;

    assign in_use       = in_use_reg;
    assign forever_mask = forever_reg;
    assign count        = count_reg;

    // Ranks are dense, so at most one slot matches.
    always_comb
    begin
        lookup_slot = '0;
        lookup_hit  = 1'b0;
        for (int i = 0; i < WAITERS; i++)
        begin
            if (in_use_reg[i] && rank_reg[i] == lookup_rank)
            begin
                lookup_slot = SLOT_W'(i);
                lookup_hit  = 1'b1;
            end
        end
    end

    assign rem_rank = rank_reg[op.slot];

    always_comb
    begin
        in_use_next  = in_use_reg;
        forever_next = forever_reg;
        rank_next    = rank_reg;
        count_next   = count_reg;
        if (op.rem)
        begin
            // close the gap behind the removed waiter
            for (int i = 0; i < WAITERS; i++)
            begin
                if (in_use_reg[i] && rank_reg[i] > rem_rank)
                begin
                    rank_next[i] = rank_reg[i] - SLOT_W'(1);
                end
            end
            in_use_next[op.slot] = 1'b0;
            rank_next[op.slot]   = '0;
            count_next           = count_reg - CNT_W'(1);
        end
        else if (op.ins)
        begin
            in_use_next[op.slot]  = 1'b1;
            forever_next[op.slot] = op.no_expiry;
            rank_next[op.slot]    = count_reg[SLOT_W-1:0];
            count_next            = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= '0;
            forever_reg <= '0;
            count_reg   <= '0;
            for (int i = 0; i < WAITERS; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            in_use_reg  <= in_use_next;
            forever_reg <= forever_next;
            count_reg   <= count_next;
            rank_reg    <= rank_next;
        end
    end

endmodule

[rtl/event_object_waiter_queue.sv]
`timescale 1ns / 1ps

// Channel   Ports                                      Transfer
// command   start, busy, cmd, waiter_id, timeout_ticks item taken when start && !busy
// result    result_valid, client_id, status, last      one cycle per item, no stall
// config    cfg_wr_en, cfg_index, cfg_data              written when cfg_wr_en is high
//
// Set in auto mode, reset and wait finish at the accepting edge, which registers any
// result. Set in manual mode grants one waiter a cycle. Tick reads one countdown a
// cycle from the countdown RAM, then flushes the final timeout. busy drops at the edge
// that registers the last result. Start-signaled is written only when idle and empty,
// with no command. Reset clears the queue and the mode; the event starts unsignaled.

module event_object_waiter_queue
    import eowq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           cmd,
    input  logic [ID_W-1:0]      waiter_id,
    input  logic [TICK_W-1:0]    timeout_ticks,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 result_valid,
    output logic [ID_W-1:0]      client_id,
    output logic [1:0]           status,
    output logic                 last
);

    state_t             state_reg;
    state_t             state_next;
    logic               manual_reg;
    logic               flag_reg;
    logic               flag_next;
    logic [SLOT_W-1:0]  ptr_reg;
    logic [SLOT_W-1:0]  ptr_next;
    logic [CNT_W-1:0]   left_reg;
    logic [CNT_W-1:0]   left_next;
    logic [SLOT_W-1:0]  eval_slot_reg;
    logic [SLOT_W-1:0]  eval_slot_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [ID_W-1:0]    pend_id_reg;
    logic [ID_W-1:0]    pend_id_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    logic [ID_W-1:0]    res_id_reg;
    logic [ID_W-1:0]    res_id_next;
    status_t            res_status_reg;
    status_t            res_status_next;
    logic               res_last_reg;
    logic               res_last_next;

    logic               accept;
    cmd_t               cmd_in;
    slot_op_t           op;
    logic [SLOT_W-1:0]  lookup_rank;
    logic [SLOT_W-1:0]  lookup_slot;
    logic               lookup_hit;
    logic [WAITERS-1:0] in_use;
    logic [WAITERS-1:0] forever_mask;
    logic [CNT_W-1:0]   count;
    logic               count_zero;
    logic               count_one;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [TICK_W-1:0]  ram_wdata;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [TICK_W-1:0]  ram_rdata;
    logic               eval_forever;
    logic               expire;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign cmd_in     = cmd_t'(cmd);
    assign count_zero = (count == '0);
    assign count_one  = (count == CNT_W'(1));

    assign result_valid = res_valid_reg;
    assign client_id    = res_id_reg;
    assign status       = res_status_reg;
    assign last         = res_last_reg;

    eowq_slots u_slots (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .lookup_rank  (lookup_rank),
        .lookup_slot  (lookup_slot),
        .lookup_hit   (lookup_hit),
        .in_use       (in_use),
        .forever_mask (forever_mask),
        .count        (count)
    );

    // Write-back of the evaluated slot never meets the read of the next one:
    // they are different waiters.
    eowq_ram #(
        .WIDTH (TICK_W),
        .DEPTH (WAITERS)
    ) u_ticks_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign eval_forever = forever_mask[eval_slot_reg];
    // count down one, expire on reaching zero
    assign expire       = !eval_forever && (ram_rdata[TICK_W-1:1] == '0);
    assign lookup_rank  = (state_reg == ST_TICK) ? (ptr_reg + SLOT_W'(1)) : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd_in == CMD_SET && manual_reg && !count_zero)
                begin
                    state_next = ST_SET_ALL;
                end
                else if (accept && cmd_in == CMD_TICK && !count_zero)
                begin
                    state_next = ST_TICK;
                end
            end
            ST_SET_ALL:
            begin
                if (count_one || count_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (left_reg == CNT_W'(1))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        flag_next       = flag_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        eval_slot_next  = eval_slot_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        res_valid_next  = 1'b0;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        res_last_next   = 1'b0;
        op              = '0;
        ram_we          = 1'b0;
        ram_waddr       = waiter_id;
        ram_wdata       = timeout_ticks;
        ram_raddr       = lookup_slot;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_in)
                        CMD_SET:
                        begin
                            if (manual_reg || !lookup_hit)
                            begin
                                flag_next = 1'b1;
                            end
                            else
                            begin
                                op.rem          = 1'b1;
                                op.slot         = lookup_slot;
                                res_valid_next  = 1'b1;
                                res_id_next     = lookup_slot;
                                res_status_next = STATUS_GRANTED;
                                res_last_next   = 1'b1;
                            end
                        end
                        CMD_RESET:
                        begin
                            flag_next = 1'b0;
                        end
                        CMD_WAIT:
                        begin
                            res_valid_next = 1'b1;
                            res_id_next    = waiter_id;
                            res_last_next  = 1'b1;
                            if (in_use[waiter_id])
                            begin
                                res_status_next = STATUS_REJECTED;
                            end
                            else if (flag_reg)
                            begin
                                res_status_next = STATUS_GRANTED;
                                if (!manual_reg)
                                begin
                                    flag_next = 1'b0;
                                end
                            end
                            else if (timeout_ticks == '0)
                            begin
                                res_status_next = STATUS_TIMED_OUT;
                            end
                            else
                            begin
                                res_status_next = STATUS_QUEUED;
                                op.ins          = 1'b1;
                                op.slot         = waiter_id;
                                op.no_expiry    = (timeout_ticks == '1);
                                ram_we          = 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            // fetch the oldest countdown
                            ptr_next        = '0;
                            left_next       = count;
                            eval_slot_next  = lookup_slot;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            flag_next = flag_reg;
                        end
                    endcase
                end
                else if (cfg_wr_en && cfg_idx_t'(cfg_index) == CFG_START_SIGNALED
                         && count_zero)
                begin
                    flag_next = cfg_data[0];
                end
            end
            ST_SET_ALL:
            begin
                if (lookup_hit)
                begin
                    op.rem          = 1'b1;
                    op.slot         = lookup_slot;
                    res_valid_next  = 1'b1;
                    res_id_next     = lookup_slot;
                    res_status_next = STATUS_GRANTED;
                    res_last_next   = count_one;
                end
            end
            ST_TICK:
            begin
                left_next      = left_reg - CNT_W'(1);
                eval_slot_next = lookup_slot;
                ram_waddr      = eval_slot_reg;
                ram_wdata      = ram_rdata - TICK_W'(1);
                if (expire)
                begin
                    // next waiter takes over this rank
                    op.rem          = 1'b1;
                    op.slot         = eval_slot_reg;
                    pend_valid_next = 1'b1;
                    pend_id_next    = eval_slot_reg;
                    if (pend_valid_reg)
                    begin
                        res_valid_next  = 1'b1;
                        res_id_next     = pend_id_reg;
                        res_status_next = STATUS_TIMED_OUT;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + SLOT_W'(1);
                    ram_we   = !eval_forever;
                end
            end
            ST_FLUSH:
            begin
                // hold the final timeout back until now so it can carry last
                if (pend_valid_reg)
                begin
                    res_valid_next  = 1'b1;
                    res_id_next     = pend_id_reg;
                    res_status_next = STATUS_TIMED_OUT;
                    res_last_next   = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            manual_reg     <= 1'b0;
            flag_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            flag_reg       <= flag_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_wr_en && cfg_idx_t'(cfg_index) == CFG_MANUAL_RESET)
            begin
                manual_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        left_reg       <= left_next;
        eval_slot_reg  <= eval_slot_next;
        pend_id_reg    <= pend_id_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

endmodule
